>>> rtl/assert_macros.svh
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rgbaovl_pkg.sv
// Package: types, constants and register codes of the overlay blender.
`default_nettype none

package rgbaovl_pkg;

   localparam int OVERLAY_MAX_W_DEF = 64;
   localparam int OVERLAY_MAX_H_DEF = 64;
   localparam int MAX_FRAME_DIM_DEF = 4096;

   localparam int STORE_DEPTH = 4096;
   localparam int STORE_AW    = 12;
   localparam int CHAN_W      = 8;
   localparam int FRAME_DIM_W = 13;
   localparam int OV_DIM_W    = 7;
   localparam int ORIGIN_W    = 14;

   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 1;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // word kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_OVERLAY_WIDTH  = 3'd2;
   localparam logic [2:0] REG_OVERLAY_HEIGHT = 3'd3;
   localparam logic [2:0] REG_OVERLAY_LEFT   = 3'd4;
   localparam logic [2:0] REG_OVERLAY_TOP    = 3'd5;

   localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST    = 13'd640;
   localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
   localparam logic [OV_DIM_W-1:0]    OVERLAY_WIDTH_RST  = 7'd64;
   localparam logic [OV_DIM_W-1:0]    OVERLAY_HEIGHT_RST = 7'd64;
   localparam logic [ORIGIN_W-1:0]    OVERLAY_LEFT_RST   = 14'd0;
   localparam logic [ORIGIN_W-1:0]    OVERLAY_TOP_RST    = 14'd0;

   typedef struct packed {
      logic [FRAME_DIM_W-1:0] frame_width;
      logic [FRAME_DIM_W-1:0] frame_height;
      logic [OV_DIM_W-1:0]    overlay_width;
      logic [OV_DIM_W-1:0]    overlay_height;
      logic [ORIGIN_W-1:0]    overlay_left;
      logic [ORIGIN_W-1:0]    overlay_top;
   } cfg_type;

   // one classified word between front and back
   typedef struct packed {
      logic                is_load;
      logic [STORE_AW-1:0] addr;
      logic [CHAN_W-1:0]   blue;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   alpha;
      logic                in_window;
      logic                line_end;
      logic                frame_end;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/rgbaovl_front.sv
// Front end: accepts words, tracks raster position and classifies each pixel.
`default_nettype none

module rgbaovl_front #(
   parameter int OVERLAY_MAX_W = rgbaovl_pkg::OVERLAY_MAX_W_DEF,
   parameter int OVERLAY_MAX_H = rgbaovl_pkg::OVERLAY_MAX_H_DEF,
   parameter int MAX_FRAME_DIM = rgbaovl_pkg::MAX_FRAME_DIM_DEF
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_tvalid,
   output logic                                     req_tready,
   input  wire  [rgbaovl_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire  [rgbaovl_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  rgbaovl_pkg::cfg_type                     cfg,
   input  rgbaovl_pkg::queue_status_type            q_status,
   output logic                                     q_push,
   output rgbaovl_pkg::queue_entry_type             q_entry
);
   import rgbaovl_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_DIM);
   localparam int CMP_W = (CNT_W > FRAME_DIM_W) ? CNT_W : FRAME_DIM_W;
   localparam int SW    = CMP_W + 2;

   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0] col_eff, row_eff;

   logic                  kind, frame_start;
   logic [STORE_AW-1:0]   load_addr;
   logic [FRAME_DIM_W-1:0] fw, fh;
   logic [OV_DIM_W-1:0]   ow, oh;
   logic [CMP_W-1:0]      col_x, row_x, fw_x, fh_x;
   logic signed [SW-1:0]  dx, dy;
   logic                  in_x, in_y, in_window, line_end, frame_end;
   logic [2*OV_DIM_W-1:0] idx_full;

   assign kind        = req_tuser[0];
   assign frame_start = req_tuser[1];
   assign load_addr   = req_tdata[11:0];

   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready;

   // clamp the window and frame sizes
   always_comb begin
      if (cfg.frame_width == '0) fw = FRAME_DIM_W'(1);
      else if (32'(cfg.frame_width) > MAX_FRAME_DIM) fw = FRAME_DIM_W'(MAX_FRAME_DIM);
      else fw = cfg.frame_width;
      if (cfg.frame_height == '0) fh = FRAME_DIM_W'(1);
      else if (32'(cfg.frame_height) > MAX_FRAME_DIM) fh = FRAME_DIM_W'(MAX_FRAME_DIM);
      else fh = cfg.frame_height;
      if (32'(cfg.overlay_width) > OVERLAY_MAX_W) ow = OV_DIM_W'(OVERLAY_MAX_W);
      else ow = cfg.overlay_width;
      if (32'(cfg.overlay_height) > OVERLAY_MAX_H) oh = OV_DIM_W'(OVERLAY_MAX_H);
      else oh = cfg.overlay_height;
   end

   assign col_eff = frame_start ? '0 : col_ff;
   assign row_eff = frame_start ? '0 : row_ff;

   assign col_x = CMP_W'(col_eff);
   assign row_x = CMP_W'(row_eff);
   assign fw_x  = CMP_W'(fw);
   assign fh_x  = CMP_W'(fh);

   assign dx = $signed({{(SW-CNT_W){1'b0}}, col_eff})
             - $signed({{(SW-ORIGIN_W){cfg.overlay_left[ORIGIN_W-1]}}, cfg.overlay_left});
   assign dy = $signed({{(SW-CNT_W){1'b0}}, row_eff})
             - $signed({{(SW-ORIGIN_W){cfg.overlay_top[ORIGIN_W-1]}}, cfg.overlay_top});

   assign in_x = !dx[SW-1] && (dx < $signed({{(SW-OV_DIM_W){1'b0}}, ow}));
   assign in_y = !dy[SW-1] && (dy < $signed({{(SW-OV_DIM_W){1'b0}}, oh}));
   assign in_window = (col_x < fw_x) && (row_x < fh_x) && in_x && in_y;

   assign line_end  = col_x >= (fw_x - CMP_W'(1));
   assign frame_end = line_end && (row_x >= (fh_x - CMP_W'(1)));

   // store index wraps at the store depth
   assign idx_full = (2*OV_DIM_W)'(dy[OV_DIM_W-1:0]) * (2*OV_DIM_W)'(ow)
                   + (2*OV_DIM_W)'(dx[OV_DIM_W-1:0]);

   always_comb begin
      q_entry.is_load   = (kind == KIND_LOAD);
      q_entry.addr      = (kind == KIND_LOAD) ? load_addr : idx_full[STORE_AW-1:0];
      q_entry.blue      = req_tdata[19:12];
      q_entry.green     = req_tdata[27:20];
      q_entry.red       = req_tdata[35:28];
      q_entry.alpha     = req_tdata[43:36];
      q_entry.in_window = in_window;
      q_entry.line_end  = line_end;
      q_entry.frame_end = frame_end;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push && kind == KIND_PIXEL) begin
         if (line_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_eff + CNT_W'(1);
         end else begin
            col_in = col_eff + CNT_W'(1);
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rgbaovl_fifo.sv
// Short queue of classified words between front and back.
`default_nettype none

module rgbaovl_fifo (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               push,
   input  rgbaovl_pkg::queue_entry_type      push_entry,
   input  wire                               pop,
   output rgbaovl_pkg::queue_entry_type      pop_entry,
   output rgbaovl_pkg::queue_status_type     status
);
   import rgbaovl_pkg::*;

   queue_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + QCNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

>>> rtl/rgbaovl_back.sv
// Back end: overlay store, blend pipeline and result register.
`default_nettype none

module rgbaovl_back (
   input  wire                                  clock,
   input  wire                                  reset,
   input  rgbaovl_pkg::queue_entry_type         q_entry,
   input  rgbaovl_pkg::queue_status_type        q_status,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [rgbaovl_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,
   output logic [rgbaovl_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import rgbaovl_pkg::*;

   localparam int PROD_W = 2 * CHAN_W;

   // x / 255 for x below 65535, by reciprocal with correction
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] s;
      s = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:CHAN_W]);
      return s[PROD_W-1:CHAN_W];
   endfunction

   logic [31:0] store_mem [STORE_DEPTH];

   logic adv;

   // stage 1: store read
   logic                  s1_valid_ff;
   logic [31:0]           s1_ov_ff;
   logic [3*CHAN_W-1:0]   s1_base_ff;
   logic                  s1_inside_ff, s1_le_ff, s1_fe_ff;

   // stage 2: products
   logic                  s2_valid_ff;
   logic [PROD_W-1:0]     s2_num_ff [3];
   logic [3*CHAN_W-1:0]   s2_base_ff;
   logic                  s2_inside_ff, s2_le_ff, s2_fe_ff;
   logic [PROD_W-1:0]     num_in [3];
   logic [CHAN_W-1:0]     s1_alpha, s1_inv_alpha;

   // stage 3: result register
   logic                  rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_fe_ff;

   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = adv && !q_status.empty;

   always_ff @(posedge clock) begin
      if (q_pop && q_entry.is_load)
         store_mem[q_entry.addr] <= {q_entry.alpha, q_entry.red, q_entry.green, q_entry.blue};
   end

   always_ff @(posedge clock) begin
      if (q_pop && !q_entry.is_load) begin
         s1_ov_ff     <= store_mem[q_entry.addr];
         s1_base_ff   <= {q_entry.red, q_entry.green, q_entry.blue};
         s1_inside_ff <= q_entry.in_window;
         s1_le_ff     <= q_entry.line_end;
         s1_fe_ff     <= q_entry.frame_end;
      end
   end

   assign s1_alpha     = s1_ov_ff[31:24];
   assign s1_inv_alpha = CHAN_W'(255) - s1_alpha;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_in[c] = PROD_W'(s1_ov_ff[c*CHAN_W +: CHAN_W]) * PROD_W'(s1_alpha)
                   + PROD_W'(s1_base_ff[c*CHAN_W +: CHAN_W]) * PROD_W'(s1_inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) s2_num_ff[c] <= num_in[c];
         s2_base_ff   <= s1_base_ff;
         s2_inside_ff <= s1_inside_ff;
         s2_le_ff     <= s1_le_ff;
         s2_fe_ff     <= s1_fe_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rsp_data_in[c*CHAN_W +: CHAN_W] = s2_inside_ff ? div255(s2_num_ff[c])
                                                        : s2_base_ff[c*CHAN_W +: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= s2_le_ff;
         rsp_fe_ff   <= s2_fe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= q_pop && !q_entry.is_load;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = RSP_TUSER_W'(rsp_fe_ff);

endmodule

`default_nettype wire

>>> rtl/rgba_overlay_alpha_blend.sv
// Top level of the BGRA overlay alpha blender: registers, front, queue and back.
`default_nettype none

//  channel  | dir | handshake             | contents
//  ---------+-----+-----------------------+------------------------------------------
//  req      | in  | req_tvalid/req_tready | load word (overlay pixel) or base pixel
//  rsp      | out | rsp_tvalid/rsp_tready | blended pixel, tlast = end of line
//  csr      | in  | APB, pready tied high | frame and overlay window registers
//
//  One word per clock in and out when rsp_tready is held high; loads give no result.
//  The accepting edge writes the queue; the word then passes through store read,
//  multiply, and divide-by-255 into the result register, which raises rsp_tvalid.
//  Reset (synchronous) clears counters, queue, stage valids and registers; the overlay
//  store is not cleared; the user must load it before any pixel reads it; the block
//  does not enforce this. rsp_tready low while a result is held freezes the
//  back pipeline; the four-word queue keeps req_tready high until it fills.

module rgba_overlay_alpha_blend #(
   parameter int OVERLAY_MAX_W = rgbaovl_pkg::OVERLAY_MAX_W_DEF,
   parameter int OVERLAY_MAX_H = rgbaovl_pkg::OVERLAY_MAX_H_DEF,
   parameter int MAX_FRAME_DIM = rgbaovl_pkg::MAX_FRAME_DIM_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // req_tdata: load_addr[11:0], blue[19:12], green[27:20], red[35:28],
   //            alpha[43:36], zero[47:44]
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [rgbaovl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: kind[0], frame_start[1]
   input  wire  [rgbaovl_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // rsp_tdata: out_blue[7:0], out_green[15:8], out_red[23:16]
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [rgbaovl_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,   // line_end
   // rsp_tuser: frame_end[0]
   output logic [rgbaovl_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [rgbaovl_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire  [rgbaovl_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [rgbaovl_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import rgbaovl_pkg::*;

`include "assert_macros.svh"

   cfg_type          cfg_ff, cfg_in;
   logic             csr_wr;
   logic [2:0]       csr_idx;

   queue_entry_type  front_entry, back_entry;
   queue_status_type q_status;
   logic             q_push, q_pop;

   // register file: written on the access phase, pready always high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_FRAME_WIDTH:    cfg_in.frame_width    = csr_pwdata[FRAME_DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg_in.frame_height   = csr_pwdata[FRAME_DIM_W-1:0];
            REG_OVERLAY_WIDTH:  cfg_in.overlay_width  = csr_pwdata[OV_DIM_W-1:0];
            REG_OVERLAY_HEIGHT: cfg_in.overlay_height = csr_pwdata[OV_DIM_W-1:0];
            REG_OVERLAY_LEFT:   cfg_in.overlay_left   = csr_pwdata[ORIGIN_W-1:0];
            REG_OVERLAY_TOP:    cfg_in.overlay_top    = csr_pwdata[ORIGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= FRAME_WIDTH_RST;
         cfg_ff.frame_height   <= FRAME_HEIGHT_RST;
         cfg_ff.overlay_width  <= OVERLAY_WIDTH_RST;
         cfg_ff.overlay_height <= OVERLAY_HEIGHT_RST;
         cfg_ff.overlay_left   <= OVERLAY_LEFT_RST;
         cfg_ff.overlay_top    <= OVERLAY_TOP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // readback; origins come back sign-extended
   always_comb begin
      case (csr_idx)
         REG_FRAME_WIDTH:    csr_prdata = CSR_DW'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:   csr_prdata = CSR_DW'(cfg_ff.frame_height);
         REG_OVERLAY_WIDTH:  csr_prdata = CSR_DW'(cfg_ff.overlay_width);
         REG_OVERLAY_HEIGHT: csr_prdata = CSR_DW'(cfg_ff.overlay_height);
         REG_OVERLAY_LEFT:
            csr_prdata = {{(CSR_DW-ORIGIN_W){cfg_ff.overlay_left[ORIGIN_W-1]}},
                          cfg_ff.overlay_left};
         REG_OVERLAY_TOP:
            csr_prdata = {{(CSR_DW-ORIGIN_W){cfg_ff.overlay_top[ORIGIN_W-1]}},
                          cfg_ff.overlay_top};
         default:            csr_prdata = '0;
      endcase
   end

   rgbaovl_front #(
      .OVERLAY_MAX_W (OVERLAY_MAX_W),
      .OVERLAY_MAX_H (OVERLAY_MAX_H),
      .MAX_FRAME_DIM (MAX_FRAME_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_entry    (front_entry)
   );

   rgbaovl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .pop_entry  (back_entry),
      .status     (q_status)
   );

   rgbaovl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_entry    (back_entry),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // a frame end is always a line end
   `ASSERT_IMPLIES(a_fe_is_le, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   // one pop per cycle at most, so a full queue is still not empty in the next cycle
   `ASSERT_NEXT(a_full_not_drained, clock, reset, q_status.full, !q_status.empty)
   // output register is empty straight after reset
   `ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_tvalid)

endmodule

`default_nettype wire

>>> sim/overlay_blend_check_pkg.sv
`timescale 1ns / 1ps
// Pixel predictor and expected-pixel queue for the overlay blender testbench.
package overlay_blend_check_pkg;
   import rgbaovl_pkg::*;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              line_end;
      logic              frame_end;
   } blended_pixel_type;

   class blend_checker;
      logic [31:0]         ov_store [STORE_DEPTH];
      bit                  ov_loaded [STORE_DEPTH];
      logic [STORE_AW-1:0] col_cnt;
      logic [STORE_AW-1:0] row_cnt;
      cfg_type             cfg;
      blended_pixel_type   expected_pixels [$];
      int                  mismatches;

      function new();
         foreach (ov_store[i]) begin
            ov_store[i]  = '0;
            ov_loaded[i] = 1'b0;
         end
         col_cnt             = '0;
         row_cnt             = '0;
         cfg.frame_width     = FRAME_WIDTH_RST;
         cfg.frame_height    = FRAME_HEIGHT_RST;
         cfg.overlay_width   = OVERLAY_WIDTH_RST;
         cfg.overlay_height  = OVERLAY_HEIGHT_RST;
         cfg.overlay_left    = OVERLAY_LEFT_RST;
         cfg.overlay_top     = OVERLAY_TOP_RST;
         mismatches          = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_FRAME_WIDTH:    cfg.frame_width    = value[FRAME_DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg.frame_height   = value[FRAME_DIM_W-1:0];
            REG_OVERLAY_WIDTH:  cfg.overlay_width  = value[OV_DIM_W-1:0];
            REG_OVERLAY_HEIGHT: cfg.overlay_height = value[OV_DIM_W-1:0];
            REG_OVERLAY_LEFT:   cfg.overlay_left   = value[ORIGIN_W-1:0];
            REG_OVERLAY_TOP:    cfg.overlay_top    = value[ORIGIN_W-1:0];
            default: ;
         endcase
      endfunction

      // zero acts as one, oversize saturates
      function void frame_dims(output int fw, output int fh);
         fw = (cfg.frame_width == 0) ? 1 :
              (cfg.frame_width > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : cfg.frame_width;
         fh = (cfg.frame_height == 0) ? 1 :
              (cfg.frame_height > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : cfg.frame_height;
      endfunction

      function bit at_origin();
         return col_cnt == 0 && row_cnt == 0;
      endfunction

      // Store entry the next pixel would read; returns 0 when outside the window.
      function bit store_read_index(logic fs, output int idx);
         int fw, fh, ow, oh, col, row, dx, dy;
         frame_dims(fw, fh);
         ow  = (cfg.overlay_width > OVERLAY_MAX_W_DEF) ? OVERLAY_MAX_W_DEF : cfg.overlay_width;
         oh  = (cfg.overlay_height > OVERLAY_MAX_H_DEF) ? OVERLAY_MAX_H_DEF : cfg.overlay_height;
         col = fs ? 0 : int'(col_cnt);
         row = fs ? 0 : int'(row_cnt);
         dx  = col - int'($signed(cfg.overlay_left));
         dy  = row - int'($signed(cfg.overlay_top));
         idx = (dy * ow + dx) % STORE_DEPTH;
         return col < fw && row < fh && dx >= 0 && dx < ow && dy >= 0 && dy < oh;
      endfunction

      function int mix(int ov, int base, int a);
         return (ov * a + base * (255 - a)) / 255;
      endfunction

      function void note_word(logic kind, logic [STORE_AW-1:0] addr,
                              logic [CHAN_W-1:0] b, g, r, a, logic fs);
         int                fw, fh, idx;
         bit                in_window;
         logic [31:0]       px;
         blended_pixel_type pix;
         if (kind == KIND_LOAD) begin
            ov_store[addr]  = {a, r, g, b};
            ov_loaded[addr] = 1'b1;
            return;
         end
         in_window = store_read_index(fs, idx);
         if (fs) begin
            col_cnt = '0;
            row_cnt = '0;
         end
         pix.blue  = b;
         pix.green = g;
         pix.red   = r;
         if (in_window) begin
            px = ov_store[idx];
            if (px[31:24] == ALPHA_OPAQUE) begin
               pix.blue  = px[7:0];
               pix.green = px[15:8];
               pix.red   = px[23:16];
            end else if (px[31:24] != ALPHA_CLEAR) begin
               pix.blue  = CHAN_W'(mix(px[7:0], b, px[31:24]));
               pix.green = CHAN_W'(mix(px[15:8], g, px[31:24]));
               pix.red   = CHAN_W'(mix(px[23:16], r, px[31:24]));
            end
         end
         // counters left beyond a shrunk frame still end the line / frame
         frame_dims(fw, fh);
         pix.line_end  = col_cnt >= fw - 1;
         pix.frame_end = pix.line_end && row_cnt >= fh - 1;
         if (pix.line_end) begin
            col_cnt = '0;
            row_cnt = pix.frame_end ? '0 : row_cnt + STORE_AW'(1);
         end else begin
            col_cnt = col_cnt + STORE_AW'(1);
         end
         expected_pixels.push_back(pix);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(blended_pixel_type got);
         blended_pixel_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: pixel with none expected, expected nothing, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("blue", want.blue, got.blue);
         compare_field("green", want.green, got.green);
         compare_field("red", want.red, got.red);
         compare_field("line_end", want.line_end, got.line_end);
         compare_field("frame_end", want.frame_end, got.frame_end);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

endpackage

>>> sim/rgba_overlay_alpha_blend_tb.sv
`timescale 1ns / 1ps
// Testbench top for the overlay alpha blender: clock, drivers, stimulus and verdict.
module rgba_overlay_alpha_blend_tb;
   import rgbaovl_pkg::*;
   import overlay_blend_check_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 8;     // pipeline settle time, loads give no word out
   localparam int PHASES        = 14;
   localparam int HOLD_CYCLES   = 120;   // one long sink stall to back up the queue

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // load_addr, blue, green, red, alpha, zero pad
   logic [REQ_TUSER_W-1:0] req_tuser;   // kind, frame_start
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // out_blue, out_green, out_red
   logic                   rsp_tlast;   // line_end
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // frame_end
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_AW-1:0]      csr_paddr;
   logic [CSR_DW-1:0]      csr_pwdata;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   blend_checker blend_sb;
   int           cycle_count = 0;
   bit           calm        = 1'b0;   // no idling on either side while set
   bit           hold_req    = 1'b0;   // asks the sink for its long stall

   rgba_overlay_alpha_blend u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result monitor: sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         blend_sb.check_pixel({rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                               rsp_tlast, rsp_tuser[0]});
   end

   // Result sink: random back-pressure, one long hold on request, none while calm.
   initial begin : rsp_sink
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req   = 1'b0;
            hold_left  = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 28);
         end
      end
   end

   // One word on the request channel; valid stays up into the next word unless
   // an idle gap is drawn. The predictor sees the word once it is accepted.
   task automatic send_word(input logic kind, input logic [STORE_AW-1:0] addr,
                            input logic [CHAN_W-1:0] b, g, r, a, input logic fs);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {a, r, g, b, addr};
      req_tuser  <= {fs, kind};
      do @(posedge clock); while (!req_tready);
      blend_sb.note_word(kind, addr, b, g, r, a, fs);
   endtask

   // Overlay load with random colour; alpha favours the clear and opaque ends.
   task automatic send_load(input int addr);
      int               pick;
      logic [CHAN_W-1:0] a;
      pick = $urandom_range(0, 2);
      a    = (pick == 0) ? ALPHA_CLEAR : (pick == 1) ? ALPHA_OPAQUE : CHAN_W'($urandom);
      send_word(KIND_LOAD, STORE_AW'(addr), CHAN_W'($urandom), CHAN_W'($urandom),
                CHAN_W'($urandom), a, 1'($urandom));
   endtask

   // Base pixel. An entry is never read before it is loaded: the load goes in
   // just ahead, and now and then an already loaded entry is refreshed too.
   // Address and alpha of a pixel word are don't-care and get random bits.
   task automatic send_pixel(input logic [CHAN_W-1:0] b, g, r, input logic fs);
      int idx;
      if (blend_sb.store_read_index(fs, idx) &&
          (!blend_sb.ov_loaded[idx] || $urandom_range(0, 9) == 0))
         send_load(idx);
      send_word(KIND_PIXEL, STORE_AW'($urandom), b, g, r, CHAN_W'($urandom), fs);
   endtask

   // APB write: setup then access; upper bits of pwdata carry junk the block must drop.
   task automatic write_reg(input logic [2:0] idx, input int field, input int width);
      logic [CSR_DW-1:0] value;
      value = ($urandom << width) | (field & ((1 << width) - 1));
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      blend_sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Stop offering words and let the block drain, including loads still in flight.
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (blend_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int fw, fh, ow, oh, left, top);
      quiesce();
      write_reg(REG_FRAME_WIDTH, fw, FRAME_DIM_W);
      write_reg(REG_FRAME_HEIGHT, fh, FRAME_DIM_W);
      write_reg(REG_OVERLAY_WIDTH, ow, OV_DIM_W);
      write_reg(REG_OVERLAY_HEIGHT, oh, OV_DIM_W);
      write_reg(REG_OVERLAY_LEFT, left, ORIGIN_W);
      write_reg(REG_OVERLAY_TOP, top, ORIGIN_W);
   endtask

   // Channel value leaning towards the extremes.
   function automatic logic [CHAN_W-1:0] rand_chan();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15)
         return 8'd0;
      if (roll < 30)
         return 8'd255;
      return CHAN_W'($urandom);
   endfunction

   initial begin : stimulus
      int                n;
      int                roll;
      logic              fs;
      blend_sb    = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: 4x3 frame, 2x2 window at (1,1) holding an opaque, a clear,
      // a half-opaque and a barely visible pixel.
      configure(4, 3, 2, 2, 1, 1);
      send_word(KIND_LOAD, 12'd0, 8'h12, 8'h34, 8'h56, ALPHA_OPAQUE, 1'b0);
      send_word(KIND_LOAD, 12'd1, 8'hFF, 8'hFF, 8'hFF, ALPHA_CLEAR, 1'b1);
      send_word(KIND_LOAD, 12'd2, 8'hFF, 8'h00, 8'hFF, 8'd128, 1'b0);
      send_word(KIND_LOAD, 12'd3, 8'h00, 8'hFF, 8'h00, 8'd1, 1'b0);
      send_word(KIND_LOAD, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'd254, 1'b1);
      // a frame restarted part way through, then two lines of the new frame
      for (int i = 0; i < 14; i++)
         send_pixel(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, CHAN_W'($urandom),
                    i == 0 || i == 6);

      // Random phases, each under its own register setting.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            2: configure(0, 0, 3, 1, 0, 0);                  // zero frame size acts as one
            4: configure(8191, 4096, 127, 127, 0, 0);       // saturating sizes
            5: configure(8, 6, 64, 64, -60, -60);           // far corner of the store
            7: configure(5, 4, 0, 0, 1, 1);                 // empty window
            8: configure(6, 5, 4, 3, -8192, 8191);          // origin register extremes
            9: configure(6, 5, 4, 3, 4096, -4096);
            default: configure($urandom_range(1, 10), $urandom_range(1, 6),
                               $urandom_range(1, 9), $urandom_range(1, 6),
                               int'($urandom_range(0, 14)) - 4,
                               int'($urandom_range(0, 10)) - 4);
         endcase
         calm = (p == 6);
         if (p == 3)
            hold_req = 1'b1;   // sink stalls while we keep pushing words in
         n = $urandom_range(32, 58);
         for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               send_load($urandom_range(0, STORE_DEPTH - 1));
            end else begin
               // frame start mostly on the real origin; a stray restart now and then
               if (k == 0 || blend_sb.at_origin())
                  fs = $urandom_range(0, 9) < 8;
               else
                  fs = $urandom_range(0, 99) < 3;
               send_pixel(rand_chan(), rand_chan(), rand_chan(), fs);
            end
         end
      end
      calm = 1'b0;

      quiesce();
      if (blend_sb.mismatches == 0 && blend_sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rgbaovl_pkg.sv
rtl/rgbaovl_front.sv
rtl/rgbaovl_fifo.sv
rtl/rgbaovl_back.sv
rtl/rgba_overlay_alpha_blend.sv
sim/overlay_blend_check_pkg.sv
sim/rgba_overlay_alpha_blend_tb.sv
